@@ hw/rtl/activation_function_unit_macros.svh @@
// Assertion macros for the activation function unit.
// Used by files that check their own pipeline; they expect clk_i and rst_ni in scope.
`ifndef ACTIVATION_FUNCTION_UNIT_MACROS_SVH
`define ACTIVATION_FUNCTION_UNIT_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define AFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger
`define AFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/afu_pkg.sv @@
// Package for the activation function unit: kind codes, fixed-point constants,
// the sigmoid table built at elaboration, and the stage control type. No dependencies.
`default_nettype none

package afu_pkg;

  // Fixed-point format and table size (table size must be a power of two)
  localparam int FRAC_BITS     = 12;
  localparam int TABLE_ENTRIES = 64;
  localparam int LOG2_ENTRIES  = $clog2(TABLE_ENTRIES);
  localparam int ONE           = 1 << FRAC_BITS;

  // Field widths
  localparam int XW  = 16;               // pre-activation and result
  localparam int AW  = XW + 1;           // magnitude of the scaled argument (up to 3x)
  localparam int SW  = FRAC_BITS + 1;    // sigmoid value in [0, ONE]
  localparam int PW  = 2 * SW;           // derivative product
  localparam int RW  = XW + 2;           // result before saturation
  localparam int MW  = 32;               // tenth-of product
  localparam int RIW = $clog2(TABLE_ENTRIES + 1);

  // Table lookup split: magnitude bits below IDX_SHIFT are the fraction
  localparam int IDX_SHIFT = FRAC_BITS + 3 - LOG2_ENTRIES;

  // 0.1 in Q0.16, and 0.1 of ONE rounded half up
  localparam int TENTH_Q16 = 6554;
  localparam int TENTH_ONE = (ONE * TENTH_Q16 + 32768) >> 16;

  typedef enum logic [2:0] {
    KIND_LINEAR  = 3'd0,
    KIND_SIGMOID = 3'd1,
    KIND_SIG3    = 3'd2,
    KIND_TANH    = 3'd3,
    KIND_STEP    = 3'd4,
    KIND_LEAKY   = 3'd5,
    KIND_SIGN    = 3'd6
  } kind_e;

  // Load enables for the sigmoid stages
  typedef struct packed {
    logic ld2;
    logic ld3;
  } sig_ctrl_t;

  typedef logic [TABLE_ENTRIES:0][SW-1:0] rom_t;

  // Shift-subtract division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid samples round(ONE / (1 + e^(-8k/N))), exponential stepped in Q32
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] step;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    h    = 64'd8 << (32 - LOG2_ENTRIES);
    term = 64'd1 << 32;
    step = 64'd1 << 32;
    e    = 64'd1 << 32;
    num  = 64'd1 << (FRAC_BITS + 32);
    for (int n = 1; n <= 12; n++) begin
      term = udiv64((term * h) >> 32, 64'(n));
      if (n % 2 == 1) begin
        step = step - term;
      end else begin
        step = step + term;
      end
    end
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      den    = (64'd1 << 32) + e;
      q      = udiv64(num + (den >> 1), den);
      rom[k] = q[SW-1:0];
      e      = (e * step + (64'd1 << 31)) >> 32;
    end
    return rom;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

endpackage

`default_nettype wire

@@ hw/rtl/afu_sigmoid.sv @@
// Sigmoid lookup of the activation function unit: table read, then interpolation
// and mirroring for negative arguments. Depends on afu_pkg.
`default_nettype none

module afu_sigmoid (
  input  logic                        clk_i,
  input  afu_pkg::sig_ctrl_t          ctrl_i,
  input  logic [afu_pkg::AW-1:0]      mag_i,   // |scaled argument|
  input  logic                        neg_i,   // argument was negative
  output logic [afu_pkg::SW-1:0]      sig_o    // s(x) in [0, ONE]
);
  import afu_pkg::*;

  logic [AW-1:0]        idx_full;
  logic                 sat;
  logic [RIW-1:0]       lo_idx;
  logic [RIW-1:0]       hi_idx;
  logic [SW-1:0]        lo_val;
  logic [SW-1:0]        hi_val;
  logic [IDX_SHIFT-1:0] frac;

  logic [SW-1:0]        lo_q,   lo_d;
  logic [SW-1:0]        diff_q, diff_d;
  logic [IDX_SHIFT-1:0] frac_q;
  logic                 neg_q;

  logic [SW+IDX_SHIFT:0] interp;
  logic [SW-1:0]         v;
  logic [SW-1:0]         sig_q,  sig_d;

  // Split the magnitude into table index and fraction; hold the last entry past the end
  always_comb begin
    idx_full = mag_i >> IDX_SHIFT;
    frac     = mag_i[IDX_SHIFT-1:0];
    sat      = (idx_full >= AW'(TABLE_ENTRIES));
    lo_idx   = sat ? RIW'(TABLE_ENTRIES) : idx_full[RIW-1:0];
    hi_idx   = sat ? RIW'(TABLE_ENTRIES) : idx_full[RIW-1:0] + RIW'(1);
    lo_val   = SIG_ROM[lo_idx];
    hi_val   = SIG_ROM[hi_idx];
    lo_d     = lo_val;
    diff_d   = (hi_val >= lo_val) ? hi_val - lo_val : '0;
  end

  // Table stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld2) begin
      lo_q   <= lo_d;
      diff_q <= diff_d;
      frac_q <= frac;
      neg_q  <= neg_i;
    end
  end

  // Interpolate, round half up, mirror by s(-x) = 1 - s(x)
  always_comb begin
    interp = (SW + IDX_SHIFT + 1)'(diff_q) * (SW + IDX_SHIFT + 1)'(frac_q)
             + (SW + IDX_SHIFT + 1)'(1 << (IDX_SHIFT - 1));
    v      = lo_q + SW'(interp >> IDX_SHIFT);
    sig_d  = neg_q ? SW'(ONE) - v : v;
  end

  // Interpolation stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld3) begin
      sig_q <= sig_d;
    end
  end

  assign sig_o = sig_q;

endmodule

`default_nettype wire

@@ hw/rtl/activation_function_unit.sv @@
// Top level of the activation function unit: five-stage pipeline around the sigmoid
// lookup. Depends on afu_pkg, afu_sigmoid and activation_function_unit_macros.svh.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: pre_activation[15:0]; tuser: mode[0]
//   m_axis    out        tdata: activation_out[15:0]
//   cfg       in         cfg_wdata_i: activation_kind[2:0], written when cfg_we_i is high
//
// One item is taken per cycle while the output is not stalled. Each result passes through the
// chain scale/abs, table read, interpolation, derivative multiply and final select,
// each behind its own register.
// Reset clears the valid bits and sets the kind to linear; the data registers keep no reset.
// A stall holds each stage only while the stage after it is full, so bubbles close up.
`default_nettype none

`include "activation_function_unit_macros.svh"

module activation_function_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_wdata_i,    // activation_kind[2:0]
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [afu_pkg::XW-1:0]     s_axis_tdata,   // pre_activation[15:0]
  input  logic [0:0]                 s_axis_tuser,   // mode[0]
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [afu_pkg::XW-1:0]     m_axis_tdata    // activation_out[15:0]
);
  import afu_pkg::*;

  localparam logic signed [RW-1:0] R_MAX   = RW'(2 ** (XW - 1) - 1);
  localparam logic signed [RW-1:0] R_MIN   = RW'(-(2 ** (XW - 1)));
  localparam logic signed [RW-1:0] ONE_R   = RW'(ONE);
  localparam logic signed [RW-1:0] TENTH_R = RW'(TENTH_ONE);

  kind_e       kind_q;
  logic [5:1]  vld_q, vld_d;
  logic [5:1]  ld;
  sig_ctrl_t   sig_ctrl;

  // Stage 1
  logic signed [XW-1:0] x1_q;
  logic                 mode1_q;
  kind_e                kind1_q;
  logic [AW-1:0]        mag1_q, mag1_d;
  logic                 neg1_q, neg1_d;
  logic signed [XW+1:0] xs;

  // Stage 2
  logic signed [XW-1:0] x2_q;
  logic                 mode2_q;
  kind_e                kind2_q;
  logic signed [XW-1:0] tenth2_q, tenth2_d;
  logic signed [MW-1:0] tprod;

  // Stage 3
  logic signed [XW-1:0] x3_q;
  logic                 mode3_q;
  kind_e                kind3_q;
  logic signed [XW-1:0] tenth3_q;
  logic [SW-1:0]        sig3;

  // Stage 4
  logic signed [XW-1:0] x4_q;
  logic                 mode4_q;
  kind_e                kind4_q;
  logic signed [XW-1:0] tenth4_q;
  logic [SW-1:0]        sig4_q;
  logic signed [SW:0]   t4_q, t4_d;
  logic [PW-1:0]        prod4_q, prod4_d;
  logic [SW:0]          s2x;
  logic                 tpos;
  logic [SW-1:0]        tmag;
  logic [SW-1:0]        opa, opb;

  // Stage 5
  logic                 mode5_q;
  kind_e                kind5_q;
  logic [XW-1:0]        out5_q, out5_d;
  logic [PW:0]          rnd;
  logic [SW-1:0]        mf;
  logic signed [RW-1:0] r;

  // Hold the activation kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_LINEAR;
    end else if (cfg_we_i) begin
      kind_q <= kind_e'(cfg_wdata_i);
    end
  end

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    ld[5] = !vld_q[5] || m_axis_tready;
    for (int k = 4; k >= 1; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
    vld_d[1] = ld[1] ? s_axis_tvalid : vld_q[1];
    for (int k = 2; k <= 5; k++) begin
      vld_d[k] = ld[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = ld[1];
  assign m_axis_tvalid = vld_q[5];
  assign m_axis_tdata  = out5_q;
  assign sig_ctrl.ld2  = ld[2];
  assign sig_ctrl.ld3  = ld[3];

  // Scale the argument for slope-3 sigmoid and tanh, then take its magnitude
  always_comb begin
    case (kind_q)
      KIND_SIG3: xs = ((XW+2)'($signed(s_axis_tdata)) <<< 1) + (XW+2)'($signed(s_axis_tdata));
      KIND_TANH: xs = (XW+2)'($signed(s_axis_tdata)) <<< 1;
      default:   xs = (XW+2)'($signed(s_axis_tdata));
    endcase
    neg1_d = xs[XW+1];
    mag1_d = neg1_d ? AW'(-xs) : AW'(xs);
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      x1_q    <= $signed(s_axis_tdata);
      mode1_q <= s_axis_tuser[0];
      kind1_q <= kind_q;
      mag1_q  <= mag1_d;
      neg1_q  <= neg1_d;
    end
  end

  // Tenth of x, rounded half up
  always_comb begin
    tprod    = MW'(x1_q) * $signed(MW'(TENTH_Q16)) + $signed(MW'(32768));
    tenth2_d = XW'(tprod >>> 16);
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      x2_q     <= x1_q;
      mode2_q  <= mode1_q;
      kind2_q  <= kind1_q;
      tenth2_q <= tenth2_d;
    end
  end

  // Sigmoid table and interpolation, stages 2 and 3
  afu_sigmoid u_sigmoid (
    .clk_i  (clk_i),
    .ctrl_i (sig_ctrl),
    .mag_i  (mag1_q),
    .neg_i  (neg1_q),
    .sig_o  (sig3)
  );

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      x3_q     <= x2_q;
      mode3_q  <= mode2_q;
      kind3_q  <= kind2_q;
      tenth3_q <= tenth2_q;
    end
  end

  // Form tanh = 2s - 1 and the derivative product operands
  always_comb begin
    s2x  = {sig3, 1'b0};
    tpos = (s2x >= (SW+1)'(ONE));
    tmag = tpos ? SW'(s2x - (SW+1)'(ONE)) : SW'((SW+1)'(ONE) - s2x);
    t4_d = tpos ? $signed({1'b0, tmag}) : -$signed({1'b0, tmag});
    if (kind3_q == KIND_TANH) begin
      opa = tmag;
      opb = tmag;
    end else begin
      opa = sig3;
      opb = SW'(ONE) - sig3;
    end
    prod4_d = PW'(opa) * PW'(opb);
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      x4_q     <= x3_q;
      mode4_q  <= mode3_q;
      kind4_q  <= kind3_q;
      tenth4_q <= tenth3_q;
      sig4_q   <= sig3;
      t4_q     <= t4_d;
      prod4_q  <= prod4_d;
    end
  end

  // Round the product and select the result for the kind and mode
  always_comb begin
    rnd = (PW+1)'(prod4_q) + (PW+1)'(1 << (FRAC_BITS - 1));
    mf  = SW'(rnd >> FRAC_BITS);
    case (kind4_q)
      KIND_LINEAR:  r = mode4_q ? ONE_R : RW'(x4_q);
      KIND_SIGMOID: r = mode4_q ? $signed(RW'(mf)) : $signed(RW'(sig4_q));
      KIND_SIG3:    r = mode4_q ? $signed(RW'(mf)) * $signed(RW'(3))
                                : $signed(RW'(sig4_q));
      KIND_TANH:    r = mode4_q ? ONE_R - $signed(RW'(mf)) : RW'(t4_q);
      KIND_STEP:    r = (mode4_q || x4_q > 0) ? ONE_R : -ONE_R;
      KIND_LEAKY: begin
        if (x4_q > 0) begin
          r = mode4_q ? ONE_R : RW'(x4_q);
        end else begin
          r = mode4_q ? TENTH_R : RW'(tenth4_q);
        end
      end
      KIND_SIGN:    r = mode4_q ? TENTH_R : ((x4_q >= 0) ? ONE_R : -ONE_R);
      default:      r = '0;
    endcase
    if (r > R_MAX) begin
      out5_d = XW'(R_MAX);
    end else if (r < R_MIN) begin
      out5_d = XW'(R_MIN);
    end else begin
      out5_d = XW'(r);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      out5_q  <= out5_d;
      mode5_q <= mode4_q;
      kind5_q <= kind4_q;
    end
  end

  // Checks on the pipeline
  `AFU_ASSERT_NOW(a_ready_needs_full, !s_axis_tready, vld_q[1], "input stalled with stage 1 empty")
  `AFU_ASSERT_NOW(a_sig_range, vld_q[3], sig3 <= SW'(ONE), "sigmoid above one")
  `AFU_ASSERT_NEXT(a_prod_hold, vld_q[4] && !ld[5], $stable(prod4_q), "stalled product changed")
  `AFU_ASSERT_NOW(a_sig_der_range, m_axis_tvalid && kind5_q == KIND_SIGMOID && mode5_q,
                  $signed(m_axis_tdata) >= 0 && $signed(m_axis_tdata) <= $signed(XW'(ONE / 4 + 1)),
                  "sigmoid derivative out of range")

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for activation_function_unit: directed table then random streams,
// each result checked against a typed value or an in-bench fixed-point model. Depends on afu_pkg.
`timescale 1ns / 100ps

module tb_top;

  import afu_pkg::*;

  localparam int          PIPE_LATENCY   = 5;
  localparam int          RANDOM_ITEMS   = 1650;
  localparam int          QUIET_TAIL     = 200;
  localparam int          CYCLE_LIMIT    = 200000;
  localparam logic [2:0]  KIND_UNDEFINED = 3'd7;
  localparam longint      ONE_Q          = longint'(ONE);

  // One item on its way in; typed_out overrides the model where set
  typedef struct packed {
    logic [2:0]         kind;
    logic               mode;
    logic signed [15:0] x;
    logic               has_typed;
    logic signed [15:0] typed_out;
  } act_row_t;

  localparam int N_DIRECTED = 26;

  // Extremes, every kind in both modes, step and sign at zero, beyond the table
  act_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{KIND_LINEAR,    1'b0,  16'sd32767, 1'b1,  16'sd32767},
    '{KIND_LINEAR,    1'b0, -16'sd32768, 1'b1, -16'sd32768},
    '{KIND_LINEAR,    1'b1, -16'sd5,     1'b1,  16'sd4096},
    '{KIND_SIGMOID,   1'b0,  16'sd0,     1'b1,  16'sd2048},
    '{KIND_SIGMOID,   1'b0,  16'sd32767, 1'b0,  16'sd0},
    '{KIND_SIGMOID,   1'b0, -16'sd32768, 1'b0,  16'sd0},
    '{KIND_SIGMOID,   1'b1,  16'sd0,     1'b1,  16'sd1024},
    '{KIND_SIGMOID,   1'b1, -16'sd3000,  1'b0,  16'sd0},
    '{KIND_SIG3,      1'b0,  16'sd10923, 1'b0,  16'sd0},
    '{KIND_SIG3,      1'b0, -16'sd32768, 1'b0,  16'sd0},
    '{KIND_SIG3,      1'b1,  16'sd1365,  1'b0,  16'sd0},
    '{KIND_TANH,      1'b0,  16'sd0,     1'b1,  16'sd0},
    '{KIND_TANH,      1'b1,  16'sd0,     1'b1,  16'sd4096},
    '{KIND_TANH,      1'b0, -16'sd32768, 1'b0,  16'sd0},
    '{KIND_STEP,      1'b0,  16'sd0,     1'b1, -16'sd4096},
    '{KIND_STEP,      1'b0,  16'sd1,     1'b1,  16'sd4096},
    '{KIND_STEP,      1'b1, -16'sd32768, 1'b1,  16'sd4096},
    '{KIND_LEAKY,     1'b0, -16'sd32768, 1'b1, -16'sd3277},
    '{KIND_LEAKY,     1'b0,  16'sd32767, 1'b1,  16'sd32767},
    '{KIND_LEAKY,     1'b1,  16'sd0,     1'b1,  16'sd410},
    '{KIND_LEAKY,     1'b1,  16'sd1,     1'b1,  16'sd4096},
    '{KIND_SIGN,      1'b0,  16'sd0,     1'b1,  16'sd4096},
    '{KIND_SIGN,      1'b0, -16'sd1,     1'b1, -16'sd4096},
    '{KIND_SIGN,      1'b1,  16'sd32767, 1'b1,  16'sd410},
    '{KIND_UNDEFINED, 1'b0,  16'sd1234,  1'b1,  16'sd0},
    '{KIND_UNDEFINED, 1'b1, -16'sd32768, 1'b1,  16'sd0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  longint unsigned    sigmoid_table [0:TABLE_ENTRIES];
  act_row_t           rows_in_flight[$];
  logic signed [15:0] expected_out[$];
  logic [2:0]         kind_mirror;
  logic [2:0]         current_kind;
  act_row_t           accepted_row;
  logic signed [15:0] want_out;
  bit                 idle_en;
  int                 stall_left;
  int                 error_count;
  int                 cycle_count;

  activation_function_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Sigmoid samples over [0,8]: the exponential is stepped in Q32
  function automatic void fill_sigmoid_table();
    longint unsigned h;
    longint unsigned term;
    longint unsigned step;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    h    = (64'd8 << 32) / TABLE_ENTRIES;
    term = 64'd1 << 32;
    step = 64'd1 << 32;
    e    = 64'd1 << 32;
    num  = 64'd1 << (FRAC_BITS + 32);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * h) >> 32) / longint'(n);
      if (n % 2 == 1) begin
        step = step - term;
      end else begin
        step = step + term;
      end
    end
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      den              = (64'd1 << 32) + e;
      sigmoid_table[k] = (num + den / 2) / den;
      e                = (e * step + (64'd1 << 31)) >> 32;
    end
  endfunction

  // Interpolated sigmoid, mirrored for negative arguments, held beyond the table
  function automatic longint sigmoid_of(longint x);
    longint unsigned mag;
    longint unsigned p;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned d;
    longint unsigned v;
    mag  = (x < 0) ? -x : x;
    p    = mag * TABLE_ENTRIES;
    idx  = p >> (FRAC_BITS + 3);
    frac = p & ((64'd1 << (FRAC_BITS + 3)) - 1);
    if (idx >= TABLE_ENTRIES) begin
      v = sigmoid_table[TABLE_ENTRIES];
    end else begin
      lo = sigmoid_table[idx];
      hi = sigmoid_table[idx + 1];
      d  = (hi >= lo) ? hi - lo : 64'd0;
      v  = lo + ((d * frac + (64'd1 << (FRAC_BITS + 2))) >> (FRAC_BITS + 3));
    end
    return (x < 0) ? ONE_Q - $signed(v) : $signed(v);
  endfunction

  // Multiply by 0.1 in Q0.16, rounding half up
  function automatic longint tenth_of_q(longint v);
    return (v * longint'(TENTH_Q16) + 32768) >>> 16;
  endfunction

  // Product of two non-negative fixed-point values, rounding half up
  function automatic longint fx_product(longint a, longint b);
    return (a * b + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [15:0] compute_activation(logic [2:0] kind, logic deriv,
                                                             logic signed [15:0] x_in);
    longint x;
    longint r;
    longint s;
    longint t;
    x = x_in;
    r = 0;
    case (kind)
      KIND_LINEAR: begin
        r = deriv ? ONE_Q : x;
      end
      KIND_SIGMOID: begin
        s = sigmoid_of(x);
        r = deriv ? fx_product(s, ONE_Q - s) : s;
      end
      KIND_SIG3: begin
        s = sigmoid_of(3 * x);
        r = deriv ? 3 * fx_product(s, ONE_Q - s) : s;
      end
      KIND_TANH: begin
        t = 2 * sigmoid_of(2 * x) - ONE_Q;
        if (t < 0) s = -t;
        else s = t;
        r = deriv ? ONE_Q - fx_product(s, s) : t;
      end
      KIND_STEP: begin
        r = deriv ? ONE_Q : ((x > 0) ? ONE_Q : -ONE_Q);
      end
      KIND_LEAKY: begin
        if (deriv) r = (x > 0) ? ONE_Q : tenth_of_q(ONE_Q);
        else r = (x > 0) ? x : tenth_of_q(x);
      end
      KIND_SIGN: begin
        r = deriv ? tenth_of_q(ONE_Q) : ((x >= 0) ? ONE_Q : -ONE_Q);
      end
      default: begin
        r = 0;
      end
    endcase
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // Random argument: full range, the steep region, near zero, extremes, saturation edges
  function automatic logic signed [15:0] pick_argument();
    int unsigned sel;
    int          v;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      v = int'($urandom);
    end else if (sel < 65) begin
      v = int'($urandom_range(0, 8191)) - 4096;
    end else if (sel < 75) begin
      v = int'($urandom_range(0, 32)) - 16;
    end else if (sel < 85) begin
      case ($urandom_range(0, 4))
        0: v = 32767;
        1: v = -32768;
        2: v = 0;
        3: v = 1;
        default: v = -1;
      endcase
    end else begin
      v = ($urandom_range(0, 1) != 0) ? 10923 : 16384;
      v = v + int'($urandom_range(0, 8)) - 4;
      if ($urandom_range(0, 1) != 0) v = -v;
    end
    return 16'(v);
  endfunction

  // Present one item and hold it until taken; maybe leave a gap after it
  task automatic send_item(act_row_t row);
    rows_in_flight.push_back(row);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.x;
    s_axis_tuser  <= row.mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (idle_en && $urandom_range(0, 99) < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Drain every outstanding item, let the pipeline settle
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (rows_in_flight.size() != 0 || expected_out.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // Change the activation kind only once the block is idle
  task automatic write_kind(logic [2:0] kind);
    drain_pipeline();
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= kind;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    current_kind = kind;
  endtask

  // Result side: stall in short bursts while idling is enabled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    = 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    = stall_left - 1;
    end else if (idle_en && $urandom_range(0, 99) < 15) begin
      m_axis_tready <= 1'b0;
      stall_left    = $urandom_range(0, 4);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Track the kind register, predict each accepted item, check each result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_mirror <= KIND_LINEAR;
    end else begin
      if (cfg_we_i) kind_mirror <= cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready && rows_in_flight.size() != 0) begin
        accepted_row = rows_in_flight.pop_front();
        if (accepted_row.has_typed) begin
          expected_out.push_back(accepted_row.typed_out);
        end else begin
          expected_out.push_back(compute_activation(kind_mirror, s_axis_tuser[0],
                                                    s_axis_tdata));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_out.size() == 0) begin
          $error("activation_out: no item outstanding, got %0d", $signed(m_axis_tdata));
          error_count++;
        end else begin
          want_out = expected_out.pop_front();
          if (m_axis_tdata !== want_out) begin
            $error("activation_out: expected %0d, got %0d", want_out, $signed(m_axis_tdata));
            error_count++;
          end
        end
      end
    end
  end

  // Guard against a hung pipeline
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    act_row_t   row;
    int         sent;
    int         phase;
    int         phase_len;
    bit         phase_idle;
    logic [2:0] next_kind;
    error_count  = 0;
    cycle_count  = 0;
    idle_en      = 1'b1;
    current_kind = KIND_LINEAR;
    fill_sigmoid_table();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; reset leaves the kind at linear
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].kind != current_kind) write_kind(directed_rows[i].kind);
      send_item(directed_rows[i]);
    end

    // Random phases: sweep every kind once, then pick at random
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      next_kind  = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
      phase_len  = $urandom_range(40, 120);
      phase_idle = ($urandom_range(0, 3) != 0);
      write_kind(next_kind);
      for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
        idle_en       = phase_idle && (sent < RANDOM_ITEMS - QUIET_TAIL);
        row.kind      = next_kind;
        row.mode      = 1'($urandom_range(0, 1));
        row.x         = pick_argument();
        row.has_typed = 1'b0;
        row.typed_out = '0;
        send_item(row);
        sent++;
      end
      phase++;
    end

    idle_en = 1'b0;
    drain_pipeline();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ activation_function_unit.f @@
+incdir+hw/rtl
hw/rtl/afu_pkg.sv
hw/rtl/afu_sigmoid.sv
hw/rtl/activation_function_unit.sv
bench/tb_top.sv
